[rtl/narrow_spike_channel_flagger_top_assert.svh]
// assertion macros for the narrow spike channel flagger rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef NARROW_SPIKE_CHANNEL_FLAGGER_TOP_ASSERT_SVH
`define NARROW_SPIKE_CHANNEL_FLAGGER_TOP_ASSERT_SVH

// same-cycle implication
`define NSCF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NSCF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nscf_pkg.sv]
// shared constants and types of the narrow spike channel flagger
// no dependencies; used by front, queue, back and top level
package nscf_pkg;

  localparam int BASELINE_SAMPLES = 4;
  localparam int SPIKE_SAMPLES    = 1;
  // older baseline starts this many channels below the tested one
  localparam int OLD_GAP          = 2;
  localparam int WIN_LEN          = 2 * BASELINE_SAMPLES + SPIKE_SAMPLES;
  localparam int LAG              = SPIKE_SAMPLES + BASELINE_SAMPLES - 1;
  localparam int PEND_LEN         = LAG + 1;

  localparam int SMP_W       = 24;
  localparam int PWR_W       = SMP_W + 1;
  localparam int SQ_W        = 2 * PWR_W;
  localparam int N_W         = $clog2(2 * BASELINE_SAMPLES);
  localparam int S_W         = PWR_W + N_W;
  localparam int Q_W         = SQ_W + N_W;
  localparam int V_W         = Q_W + N_W;
  localparam int V_LO_W      = V_W / 2;
  localparam int V_HI_W      = V_W - V_LO_W;
  localparam int DD_W        = 2 * S_W;
  localparam int SIGMA_W     = 4;
  localparam int SIG2_W      = 2 * SIGMA_W;
  localparam int SV_W        = V_W + SIG2_W;
  localparam int SIGMA_RESET = 5;

  localparam int WIN_IW  = $clog2(WIN_LEN);
  localparam int P_W     = $clog2(PEND_LEN);
  localparam int CNT_W   = $clog2(PEND_LEN + 1);
  localparam int SEEN_W  = $clog2(WIN_LEN + 1);

  localparam int QUEUE_DEPTH = 2;

  localparam int IN_TDATA_W  = 2 * SMP_W;
  localparam int OUT_TDATA_W = 8;

  // one channel handed from the front to the back
  typedef struct packed {
    logic [PWR_W-1:0]  x;
    logic [SQ_W-1:0]   sq;
    logic              flag;
    logic              last;
    logic [SEEN_W-1:0] seen;
    logic [CNT_W-1:0]  count;
    logic [P_W-1:0]    first_p;
  } nscf_job_t;

  // one result word
  typedef struct packed {
    logic flag;
    logic spike;
    logic last;
  } nscf_res_t;

endpackage

[rtl/nscf_front.sv]
// front end: accepts channel words, sums the powers and plans the results
// depends on nscf_pkg
module nscf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [nscf_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  output logic                             job_valid,
  input  logic                             job_ready,
  output nscf_pkg::nscf_job_t              job
);
  import nscf_pkg::*;

  logic              in_acc;
  logic              s1_valid_r;
  logic [PWR_W-1:0]  x_r;
  logic              flag_r;
  logic              last_r;
  logic [SEEN_W-1:0] job_seen_r;
  logic [CNT_W-1:0]  count_r;
  logic [P_W-1:0]    first_p_r;
  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] seen_nxt;
  logic [SEEN_W-1:0] top_full;
  logic [P_W-1:0]    top;
  logic [SQ_W-1:0]   sq;

  assign in_tready = !s1_valid_r || job_ready;
  assign in_acc    = in_tvalid && in_tready;

  // channel count of the dump, saturating at the window length
  assign seen_nxt = (seen_r < SEEN_W'(WIN_LEN)) ? seen_r + 1'b1 : seen_r;
  assign top_full = seen_nxt - 1'b1;
  assign top      = (top_full > SEEN_W'(LAG)) ? P_W'(LAG) : top_full[P_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      seen_r     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        seen_r     <= in_tlast ? '0 : seen_nxt;
      end else if (job_ready) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r        <= PWR_W'(in_tdata[SMP_W-1:0]) + PWR_W'(in_tdata[2*SMP_W-1:SMP_W]);
      flag_r     <= in_tuser;
      last_r     <= in_tlast;
      job_seen_r <= seen_nxt;
      if (in_tlast) begin
        // flush the whole tail of the dump
        count_r   <= CNT_W'(top) + 1'b1;
        first_p_r <= top;
      end else if (seen_nxt > SEEN_W'(LAG)) begin
        count_r   <= CNT_W'(1);
        first_p_r <= P_W'(LAG);
      end else begin
        count_r   <= '0;
        first_p_r <= '0;
      end
    end
  end

  assign sq = SQ_W'(x_r) * SQ_W'(x_r);

  assign job_valid   = s1_valid_r;
  assign job.x       = x_r;
  assign job.sq      = sq;
  assign job.flag    = flag_r;
  assign job.last    = last_r;
  assign job.seen    = job_seen_r;
  assign job.count   = count_r;
  assign job.first_p = first_p_r;

endmodule

[rtl/nscf_fifo.sv]
// short queue of planned channels between front and back
// depends on nscf_pkg
module nscf_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  nscf_pkg::nscf_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output nscf_pkg::nscf_job_t pop_job
);
  import nscf_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  nscf_job_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [FILL_W-1:0] fill_r;
  logic              push;
  logic              pop;

  assign push_ready = fill_r != FILL_W'(QUEUE_DEPTH);
  assign pop_valid  = fill_r != '0;
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[rtl/nscf_back.sv]
// back end: window of channel powers, baseline sweep and exact sigma test
// depends on nscf_pkg and the assertion macro header
`include "narrow_spike_channel_flagger_top_assert.svh"

module nscf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [nscf_pkg::SIGMA_W-1:0]      cfg_wdata,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  nscf_pkg::nscf_job_t               job,
  output logic                              res_valid,
  input  logic                              res_ready,
  output nscf_pkg::nscf_res_t               res
);
  import nscf_pkg::*;

  localparam int SVL_W = SIG2_W + V_LO_W;
  localparam int SVH_W = SIG2_W + V_HI_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIFF = 6'b001000,
    ST_PROD = 6'b010000,
    ST_CMP  = 6'b100000
  } state_t;

  // window position k belongs to the baseline of the channel at position p
  function automatic logic in_base(input logic [P_W-1:0] p, input logic [WIN_IW-1:0] k,
                                   input logic [SEEN_W-1:0] seen);
    int  pi;
    int  ki;
    int  si;
    logic older;
    logic newer;
    pi    = int'(p);
    ki    = int'(k);
    si    = int'(seen);
    older = (ki >= pi + OLD_GAP) && (ki <= pi + BASELINE_SAMPLES) &&
            (ki < WIN_LEN) && (ki < si);
    newer = (pi >= SPIKE_SAMPLES) && (ki >= pi - SPIKE_SAMPLES - BASELINE_SAMPLES + 1) &&
            (ki <= pi - SPIKE_SAMPLES);
    return older || newer;
  endfunction

  state_t              state_r;
  state_t              state_nxt;
  logic [PWR_W-1:0]    win_r    [WIN_LEN];
  logic [SQ_W-1:0]     sq_win_r [WIN_LEN];
  logic                pend_r   [PEND_LEN];
  logic [SEEN_W-1:0]   seen_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [P_W-1:0]      p_r;
  logic                last_r;
  logic [WIN_IW-1:0]   k_r;
  logic [N_W-1:0]      n_r;
  logic [S_W-1:0]      s_r;
  logic [Q_W-1:0]      q_r;
  logic [PWR_W-1:0]    x_r;
  logic [S_W-1:0]      nx_r;
  logic [V_W-1:0]      nq_r;
  logic [V_W-1:0]      ss_r;
  logic                pos_r;
  logic [S_W-1:0]      d_r;
  logic [V_W-1:0]      v_r;
  logic [DD_W-1:0]     dd_r;
  logic [SVL_W-1:0]    svl_r;
  logic [SVH_W-1:0]    svh_r;
  logic [SIG2_W-1:0]   sig2_r;
  logic                out_valid_r;
  nscf_res_t           res_r;

  logic                job_pop;
  logic                out_load;
  logic                acc_done;
  logic                base_hit;
  logic [SV_W-1:0]     sv;
  logic                spike;
  logic                last_nxt;

  assign job_ready = state_r == ST_IDLE;
  assign job_pop   = job_valid && job_ready;
  assign out_load  = (state_r == ST_CMP) && (!out_valid_r || res_ready);
  assign acc_done  = k_r == WIN_IW'(WIN_LEN - 1);
  assign base_hit  = in_base(p_r, k_r, seen_r);
  assign sv        = {svh_r, {V_LO_W{1'b0}}} + SV_W'(svl_r);
  assign spike     = pos_r && (SV_W'(dd_r) > sv);
  assign last_nxt  = last_r && (p_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (job_pop && job.count != '0) state_nxt = ST_ACC;
      ST_ACC:  if (acc_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIFF;
      ST_DIFF: state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_CMP;
      ST_CMP: begin
        if (out_load) state_nxt = (cnt_r == CNT_W'(1)) ? ST_IDLE : ST_ACC;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sig2_r      <= SIG2_W'(SIGMA_RESET * SIGMA_RESET);
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        sig2_r <= SIG2_W'(cfg_wdata) * SIG2_W'(cfg_wdata);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (job_pop) begin
          for (int i = WIN_LEN - 1; i > 0; i--) begin
            win_r[i]    <= win_r[i-1];
            sq_win_r[i] <= sq_win_r[i-1];
          end
          for (int i = PEND_LEN - 1; i > 0; i--) begin
            pend_r[i] <= pend_r[i-1];
          end
          win_r[0]    <= job.x;
          sq_win_r[0] <= job.sq;
          pend_r[0]   <= job.flag;
          seen_r      <= job.seen;
          cnt_r       <= job.count;
          p_r         <= job.first_p;
          last_r      <= job.last;
          k_r         <= '0;
          n_r         <= '0;
          s_r         <= '0;
          q_r         <= '0;
        end
      end
      ST_ACC: begin
        if (base_hit) begin
          n_r <= n_r + 1'b1;
          s_r <= s_r + S_W'(win_r[k_r]);
          q_r <= q_r + Q_W'(sq_win_r[k_r]);
        end
        if (k_r == WIN_IW'(p_r)) x_r <= win_r[k_r];
        if (!acc_done) k_r <= k_r + 1'b1;
      end
      ST_MUL: begin
        nx_r <= S_W'(n_r) * S_W'(x_r);
        nq_r <= V_W'(n_r) * V_W'(q_r);
        ss_r <= V_W'(s_r) * V_W'(s_r);
      end
      ST_DIFF: begin
        pos_r <= nx_r > s_r;
        d_r   <= nx_r - s_r;
        v_r   <= nq_r - ss_r;
      end
      ST_PROD: begin
        dd_r  <= DD_W'(d_r) * DD_W'(d_r);
        svl_r <= SVL_W'(sig2_r) * SVL_W'(v_r[V_LO_W-1:0]);
        svh_r <= SVH_W'(sig2_r) * SVH_W'(v_r[V_W-1:V_LO_W]);
      end
      ST_CMP: begin
        if (out_load) begin
          res_r.flag  <= pend_r[p_r] | spike;
          res_r.spike <= spike;
          res_r.last  <= last_nxt;
          if (cnt_r != CNT_W'(1)) begin
            cnt_r <= cnt_r - 1'b1;
            p_r   <= p_r - 1'b1;
            k_r   <= '0;
            n_r   <= '0;
            s_r   <= '0;
            q_r   <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

  `NSCF_ASSERT_NEXT(a_last_word_ends_job, out_load && last_nxt, state_r == ST_IDLE, "dump end left work")
  `NSCF_ASSERT_NOW(a_var_not_negative, state_r == ST_DIFF, nq_r >= ss_r, "baseline variance wrapped")
  `NSCF_ASSERT_NOW(a_job_bounds, state_r != ST_IDLE, cnt_r != '0 && CNT_W'(p_r) >= cnt_r - 1'b1, "bad position count")

endmodule

[rtl/narrow_spike_channel_flagger_top.sv]
// top level of the narrow spike channel flagger
// depends on nscf_pkg, nscf_front, nscf_fifo and nscf_back
//
//   channel  dir  tdata (low bit first)      tuser            tlast
//   in_      in   pol_a[23:0], pol_b[47:24]  already_flagged  last_channel
//   out_     out  flag[0], zeros[7:1]        spike            last_of_dump
//   cfg_     in   cfg_wdata = sigma (4 bits), written when cfg_we is high
//
// the front registers each accepted word; the back pops it when idle and then,
// for each result word, sweeps the window slot by slot for the
// baseline sums, then runs multiply, subtract, multiply and compare stages
// an ordinary channel yields one result word once more than LAG channels are seen, the last
// channel of a dump one word per flushed channel, other channels none and leave the back idle
// rst_n is synchronous, active low; sigma comes back as 5, no clearing pass
// a stalled output register holds the back in its compare step, while the
// two-entry queue lets the front keep taking words
module narrow_spike_channel_flagger_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration: sigma
  input  logic                              cfg_we,
  input  logic [nscf_pkg::SIGMA_W-1:0]      cfg_wdata,
  // input channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [nscf_pkg::IN_TDATA_W-1:0]   in_tdata,   // pol_a, pol_b
  input  logic                              in_tuser,   // already_flagged
  input  logic                              in_tlast,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [nscf_pkg::OUT_TDATA_W-1:0]  out_tdata,  // flag, then zero fill
  output logic                              out_tuser,  // spike
  output logic                              out_tlast
);
  import nscf_pkg::*;

  // front to queue
  logic      fr_valid;
  logic      fr_ready;
  nscf_job_t fr_job;
  // queue to back
  logic      bk_valid;
  logic      bk_ready;
  nscf_job_t bk_job;
  // back result word
  nscf_res_t res;

  nscf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  nscf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_job   (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_job    (bk_job)
  );

  nscf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // flag sits in bit 0 of the data byte
  assign out_tdata = {{(OUT_TDATA_W - 1){1'b0}}, res.flag};
  assign out_tuser = res.spike;
  assign out_tlast = res.last;

endmodule

[bench/tb.sv]
// self-checking bench for narrow_spike_channel_flagger_top: streams spectral dumps, predicts
// every flag word in a scoreboard class and compares each accepted output word field by field
// depends on nscf_pkg and the flagger rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nscf_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  // a last channel may flush up to five result words, leave room beyond that
  localparam int SETTLE       = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 45;
  localparam int MAX_REPORTS  = 10;
  localparam int CYCLE_LIMIT  = 300000;
  localparam logic [SMP_W-1:0] SMP_MAX = '1;

  // ---------------------------------------------------------------------------
  // flag predictor: own copy of the power window, pending flags, fill count
  // and sigma; expected words wait in a queue until the output side takes them
  // ---------------------------------------------------------------------------
  class flag_scoreboard;
    logic [PWR_W-1:0]   power_hist [WIN_LEN];
    logic               flag_hist  [PEND_LEN];
    int                 fill;
    logic [SIGMA_W-1:0] sigma;
    nscf_res_t          expected_words [$];
    int                 mismatches;
    int                 words_checked;
    int                 spikes_seen;
    int                 flushes_seen;

    function new();
      foreach (power_hist[k]) power_hist[k] = '0;
      foreach (flag_hist[k]) flag_hist[k] = 1'b0;
      fill = 0;
      sigma = SIGMA_W'(SIGMA_RESET);
      mismatches = 0;
      words_checked = 0;
      spikes_seen = 0;
      flushes_seen = 0;
    endfunction

    // exact integer sigma test on the channel at window slot p (0 = newest)
    function bit spike_at(int p);
      logic [63:0] x, n, s, q, v, d, spread, sig2;
      int k, lo;
      x = 64'(power_hist[p]);
      n = 0;
      s = 0;
      q = 0;
      // older side of the baseline, only slots filled in this dump
      for (k = p + OLD_GAP; k <= p + BASELINE_SAMPLES; k++) begin
        if (k < WIN_LEN && k < fill) begin
          v = 64'(power_hist[k]);
          n += 1;
          s += v;
          q += v * v;
        end
      end
      // newer side
      if (p >= SPIKE_SAMPLES) begin
        lo = p - SPIKE_SAMPLES - BASELINE_SAMPLES + 1;
        if (lo < 0) lo = 0;
        for (k = lo; k <= p - SPIKE_SAMPLES; k++) begin
          v = 64'(power_hist[k]);
          n += 1;
          s += v;
          q += v * v;
        end
      end
      if (n == 0) return 1'b0;
      if (n * x <= s) return 1'b0;
      d = n * x - s;
      spread = n * q - s * s;
      sig2 = 64'(sigma) * 64'(sigma);
      // fits in 64 bits: spread < 2^56, sig2 <= 225
      return (d * d) > (sig2 * spread);
    endfunction

    function nscf_res_t word_at(int p, bit last);
      nscf_res_t w;
      bit sp;
      sp = spike_at(p);
      w.flag = flag_hist[p] | sp;
      w.spike = sp;
      w.last = last;
      return w;
    endfunction

    function void take_channel(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b, logic fl, logic last);
      int k, top;
      for (k = WIN_LEN - 1; k > 0; k--) power_hist[k] = power_hist[k-1];
      power_hist[0] = {1'b0, a} + {1'b0, b};
      for (k = PEND_LEN - 1; k > 0; k--) flag_hist[k] = flag_hist[k-1];
      flag_hist[0] = fl;
      if (fill < WIN_LEN) fill++;
      if (last) begin
        top = fill - 1;
        if (top > LAG) top = LAG;
        for (k = top; k >= 0; k--) expected_words.push_back(word_at(k, k == 0));
        fill = 0;
      end else if (fill > LAG) begin
        expected_words.push_back(word_at(LAG, 1'b0));
      end
    endfunction

    function void note_mismatch(string what, nscf_res_t exp_w, nscf_res_t act_w);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] mismatch on %s: expected flag=%0b spike=%0b last=%0b, got flag=%0b spike=%0b last=%0b",
                 $realtime, what, exp_w.flag, exp_w.spike, exp_w.last,
                 act_w.flag, act_w.spike, act_w.last);
    endfunction

    function void check_word(logic flag, logic spike, logic last);
      nscf_res_t act_w, exp_w;
      act_w.flag = flag;
      act_w.spike = spike;
      act_w.last = last;
      words_checked++;
      if (spike === 1'b1) spikes_seen++;
      if (last === 1'b1) flushes_seen++;
      if (expected_words.size() == 0) begin
        note_mismatch("unexpected word", '0, act_w);
        return;
      end
      exp_w = expected_words.pop_front();
      if (act_w.flag !== exp_w.flag) note_mismatch("flag", exp_w, act_w);
      if (act_w.spike !== exp_w.spike) note_mismatch("spike", exp_w, act_w);
      if (act_w.last !== exp_w.last) note_mismatch("last_of_dump", exp_w, act_w);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // dut signals
  // ---------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [SIGMA_W-1:0]     cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // pol_a, pol_b
  logic                   in_tuser;   // already_flagged
  logic                   in_tlast;   // last_channel
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // flag, then zero fill
  logic                   out_tuser;  // spike
  logic                   out_tlast;  // last_of_dump

  narrow_spike_channel_flagger_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  flag_scoreboard sb = new();

  // idle limits drawn per dump, 0 gives back-to-back stretches
  int  in_gap_max  = 0;
  int  out_gap_max = 0;
  // receiver wait before its next word, redrawn after each accepted word
  int  rx_wait     = 0;
  // main flow asks the receiver for one long hold-off
  bit  hold_req    = 1'b0;
  int  channels_sent = 0;
  int  dumps_sent    = 0;
  int  cycles        = 0;

  // ---------------------------------------------------------------------------
  // cycle limit
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycles, sb.expected_words.size());
      $display("** narrow_spike_channel_flagger_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // output side: ready changes on the falling edge, words sampled on the rising
  // ---------------------------------------------------------------------------
  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (hold_req) begin
        // long stall so the back end and the queue fill and in_tready drops
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else if (rx_wait > 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_word(out_tdata[0], out_tuser, out_tlast);
      rx_wait = $urandom_range(0, out_gap_max);
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // offer one channel word after a random gap and wait for the handshake
  task automatic send_channel(logic [SMP_W-1:0] a, logic [SMP_W-1:0] b, logic fl, logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, a};
    in_tuser  <= fl;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_channel(a, b, fl, last);
    channels_sent++;
    if (last) dumps_sent++;
  endtask

  // drop valid and let every expected word drain, then let the back end settle
  task automatic drain_all();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // sigma is written only with the block idle
  task automatic write_sigma(logic [SIGMA_W-1:0] value);
    drain_all();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.sigma = value;
  endtask

  function automatic logic [SMP_W-1:0] clamp_smp(longint unsigned v);
    return (v > SMP_MAX) ? SMP_MAX : v[SMP_W-1:0];
  endfunction

  // one dump of random content; most dumps are a flat baseline with a little
  // noise and occasional spikes so the sigma test lands near its threshold
  task automatic random_dump(int len);
    int style, noise, k;
    longint unsigned amp;
    logic [SMP_W-1:0] base_a, base_b, a, b;
    logic fl;
    style = $urandom_range(0, 9);
    case ($urandom_range(0, 4))
      0: noise = 0;
      1: noise = 1;
      2: noise = 7;
      3: noise = 63;
      default: noise = 1023;
    endcase
    base_a = SMP_W'($urandom() & ($urandom_range(0, 1) ? 32'h0000FF : 32'h3FFFFF));
    base_b = SMP_W'($urandom() & ($urandom_range(0, 1) ? 32'h0000FF : 32'h3FFFFF));
    for (k = 0; k < len; k++) begin
      if (style <= 1) begin
        // plain noise over the full field range
        a = SMP_W'($urandom());
        b = SMP_W'($urandom());
      end else if (style == 2) begin
        // corner values
        case ($urandom_range(0, 2))
          0: a = '0;
          1: a = SMP_MAX;
          default: a = SMP_W'($urandom());
        endcase
        case ($urandom_range(0, 2))
          0: b = '0;
          1: b = SMP_MAX;
          default: b = SMP_W'($urandom());
        endcase
      end else begin
        a = clamp_smp(longint'(base_a) + $urandom_range(0, noise));
        b = clamp_smp(longint'(base_b) + $urandom_range(0, noise));
        if ($urandom_range(0, 5) == 0) begin
          amp = longint'(noise + 1) * $urandom_range(1, 64) + $urandom_range(0, 3);
          a = clamp_smp(longint'(a) + amp);
        end
      end
      fl = ($urandom_range(0, 3) == 0);
      send_channel(a, b, fl, k == len - 1);
    end
  endtask

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 12;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // main flow: reset, directed dumps under reset sigma, then random phases
  // each under its own sigma, with extremes 0 and 15 among them
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [SIGMA_W-1:0] sigma_plan [7];
    int phase, phase_start, len, k, failures;
    sigma_plan = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd7, 4'd2, 4'd10};

    // every input known from time zero
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // dumps of one channel: empty baseline, never a spike, existing flag kept
    send_channel(SMP_MAX, SMP_MAX, 1'b1, 1'b1);
    send_channel('0, '0, 1'b0, 1'b1);
    // short dump of three: only the seen channels are flushed
    send_channel('0, '0, 1'b0, 1'b0);
    send_channel(SMP_MAX, '0, 1'b1, 1'b0);
    send_channel('0, SMP_MAX, 1'b0, 1'b1);
    // dump of exactly lag+1 on a zero baseline, spike in the middle
    for (k = 0; k < 5; k++)
      send_channel((k == 2) ? SMP_MAX : '0, '0, 1'b0, k == 4);
    // longer dump, flat baseline, full-scale spike and a pre-flagged channel
    for (k = 0; k < 12; k++)
      send_channel((k == 6) ? SMP_MAX : 24'd1000, (k == 6) ? SMP_MAX : 24'd1000,
                   k == 9, k == 11);

    for (phase = 0; phase < 7; phase++) begin
      write_sigma(sigma_plan[phase]);
      phase_start = channels_sent;
      if (phase == 1) begin
        // receiver stalls while the sender keeps offering back to back
        in_gap_max = 0;
        out_gap_max = 0;
        hold_req = 1'b1;
        random_dump(20);
      end
      while (channels_sent - phase_start < PHASE_WORDS) begin
        in_gap_max  = pick_gap();
        out_gap_max = pick_gap();
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 12);
        random_dump(len);
      end
    end

    // sender pauses until everything has come back, then a tail for stray words
    drain_all();

    failures = sb.mismatches + sb.expected_words.size();
    if (sb.expected_words.size() != 0)
      $display("%0d expected words never arrived", sb.expected_words.size());
    $display("run covered %0d channels in %0d dumps, %0d flag words checked",
             channels_sent, dumps_sent, sb.words_checked);
    $display("%0d spikes and %0d dump ends seen over 8 sigma settings, %0d mismatches",
             sb.spikes_seen, sb.flushes_seen, sb.mismatches);
    if (failures == 0) begin
      $display("** narrow_spike_channel_flagger_top: PASSED **");
    end else begin
      $display("** narrow_spike_channel_flagger_top: FAILED **");
    end
    $finish;
  end

endmodule
